/* design/windowed_sine_generator_defines.svh */
// ----------------------------------------------------------------------------
// Windowed sine generator assertion macros
// Shared property wrappers clocked on clk_i and reset by rst_ni.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_SINE_GENERATOR_DEFINES_SVH
`define WINDOWED_SINE_GENERATOR_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define WSG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: property failed");

// Check that a condition never holds outside reset.
`define WSG_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("%m: forbidden condition seen");

`endif

/* design/wsg_pkg.sv */
// ----------------------------------------------------------------------------
// Windowed sine generator package
// Shared widths, fixed-point constants, register codes and pipeline tag.
// ----------------------------------------------------------------------------
package wsg_pkg;

  localparam int unsigned IndexWidthDef = 24;
  localparam int unsigned OutWidthDef   = 16;

  localparam int unsigned ApbDataWidth = 32;
  localparam int unsigned ApbAddrWidth = 4;

  localparam int unsigned FracBits    = 30;
  localparam int unsigned ThetaWidth  = 31;
  localparam int unsigned TermWidth   = 32;
  localparam int unsigned SumWidth    = 34;
  localparam int unsigned RecipWidth  = 30;
  localparam int unsigned DivWidth    = 8;
  localparam int unsigned NumTerms    = 6;

  localparam logic [ThetaWidth-1:0] HalfPiQ30 = 31'd1686629713;

  localparam logic [DivWidth-1:0] TermDiv [NumTerms] = '{
    8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156
  };

  // floor(2^32 / TermDiv)
  localparam logic [RecipWidth-1:0] TermRecip [NumTerms] = '{
    30'd715827882, 30'd214748364, 30'd102261126,
    30'd59652323,  30'd39045157,  30'd27531841
  };

  typedef enum logic [1:0] {
    RegPeriod = 2'd0,
    RegPhase  = 2'd1,
    RegDelay  = 2'd2,
    RegEnd    = 2'd3
  } wsg_reg_e;

  typedef struct packed {
    logic valid;
    logic in_win;
    logic neg;
    logic hi;
  } wsg_tag_t;

endpackage

/* design/wsg_if.sv */
// ----------------------------------------------------------------------------
// Windowed sine generator stream interfaces
// Valid/ready channels for sample index requests and sample results.
// ----------------------------------------------------------------------------
interface wsg_in_if #(
  parameter int unsigned IndexWidth = wsg_pkg::IndexWidthDef
);
  logic                  valid;
  logic                  ready;
  logic [IndexWidth-1:0] sample_index;

  modport source (output valid, output sample_index, input ready);
  modport sink (input valid, input sample_index, output ready);
endinterface

interface wsg_out_if #(
  parameter int unsigned OutWidth = wsg_pkg::OutWidthDef
);
  logic                       valid;
  logic                       ready;
  logic signed [OutWidth-1:0] sample_value;
  logic                       in_window;

  modport source (output valid, output sample_value, output in_window, input ready);
  modport sink (input valid, input sample_value, input in_window, output ready);
endinterface

/* design/wsg_div_cell.sv */
// ----------------------------------------------------------------------------
// Long division cell
// One registered restoring step: shifts the next dividend bit into the
// remainder and appends one quotient bit.
// ----------------------------------------------------------------------------
module wsg_div_cell #(
  parameter int unsigned RemWidth = wsg_pkg::IndexWidthDef,
  parameter int unsigned AccWidth = wsg_pkg::IndexWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic [RemWidth-1:0]  divisor_i,
  input  wsg_pkg::wsg_tag_t    tag_i,
  input  logic [RemWidth-1:0]  rem_i,
  input  logic [AccWidth-1:0]  acc_i,
  output wsg_pkg::wsg_tag_t    tag_o,
  output logic [RemWidth-1:0]  rem_o,
  output logic [AccWidth-1:0]  acc_o
);
  import wsg_pkg::*;

  logic [RemWidth:0]   shifted;
  logic [RemWidth+1:0] trial;
  logic                take;
  wsg_tag_t            tag_q;
  logic [RemWidth-1:0] rem_d, rem_q;
  logic [AccWidth-1:0] acc_d, acc_q;

  always_comb begin
    shifted = {rem_i, acc_i[AccWidth-1]};
    trial   = {1'b0, shifted} - {2'b00, divisor_i};
    take    = !trial[RemWidth+1];
    rem_d   = take ? trial[RemWidth-1:0] : shifted[RemWidth-1:0];
    acc_d   = {acc_i[AccWidth-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else if (en_i) begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      acc_q <= acc_d;
    end
  end

  assign tag_o = tag_q;
  assign rem_o = rem_q;
  assign acc_o = acc_q;

endmodule

/* design/wsg_term_cell.sv */
// ----------------------------------------------------------------------------
// Taylor term cell
// Three-stage cell that derives the next sine series term from the previous
// one and folds it into the running sum.
// ----------------------------------------------------------------------------
module wsg_term_cell #(
  parameter int unsigned TermIdx = 0
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    en_i,
  input  wsg_pkg::wsg_tag_t                       tag_i,
  input  logic [wsg_pkg::TermWidth-1:0]           theta2_i,
  input  logic [wsg_pkg::TermWidth-1:0]           term_i,
  input  logic signed [wsg_pkg::SumWidth-1:0]     sum_i,
  output wsg_pkg::wsg_tag_t                       tag_o,
  output logic [wsg_pkg::TermWidth-1:0]           theta2_o,
  output logic [wsg_pkg::TermWidth-1:0]           term_o,
  output logic signed [wsg_pkg::SumWidth-1:0]     sum_o
);
  import wsg_pkg::*;

  localparam logic [DivWidth-1:0]   Div   = TermDiv[TermIdx];
  localparam logic [RecipWidth-1:0] Recip = TermRecip[TermIdx];
  localparam bit                    Sub   = (TermIdx % 2) == 0;
  localparam int unsigned           P1W   = 2 * TermWidth;
  localparam int unsigned           P2W   = TermWidth + RecipWidth;
  localparam int unsigned           P3W   = RecipWidth + DivWidth;

  wsg_tag_t                     tag1_q, tag2_q, tag3_q;
  logic [TermWidth-1:0]         th2_1_q, th2_2_q, th2_3_q;
  logic signed [SumWidth-1:0]   sum1_q, sum2_q, sum3_q;
  logic [TermWidth-1:0]         x1_q, x2_q, term3_q;
  logic [RecipWidth-1:0]        qe2_q;

  logic [P1W-1:0]               prod1;
  logic [P2W-1:0]               prod2;
  logic [P3W-1:0]               prod3;
  logic [TermWidth-1:0]         resid;
  logic [TermWidth-1:0]         term_d;
  logic signed [SumWidth-1:0]   sum_d;

  always_comb begin
    prod1  = P1W'(term_i) * P1W'(theta2_i);
    prod2  = P2W'(x1_q) * P2W'(Recip);
    prod3  = P3W'(qe2_q) * P3W'(Div);
    resid  = x2_q - prod3[TermWidth-1:0];
    term_d = TermWidth'(qe2_q) + TermWidth'(resid >= TermWidth'(Div));
    if (Sub) begin
      sum_d = sum2_q - $signed({{(SumWidth-TermWidth){1'b0}}, term_d});
    end else begin
      sum_d = sum2_q + $signed({{(SumWidth-TermWidth){1'b0}}, term_d});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
    end else if (en_i) begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q    <= prod1[FracBits+TermWidth-1:FracBits];
      th2_1_q <= theta2_i;
      sum1_q  <= sum_i;
      qe2_q   <= prod2[P2W-1:TermWidth];
      x2_q    <= x1_q;
      th2_2_q <= th2_1_q;
      sum2_q  <= sum1_q;
      term3_q <= term_d;
      th2_3_q <= th2_2_q;
      sum3_q  <= sum_d;
    end
  end

  assign tag_o    = tag3_q;
  assign theta2_o = th2_3_q;
  assign term_o   = term3_q;
  assign sum_o    = sum3_q;

endmodule

/* design/windowed_sine_generator.sv */
// ----------------------------------------------------------------------------
// Windowed sine generator
// Streams one Q1.(OutWidth-1) sine sample per sample index request, gated by
// a configurable delay/end window, with an APB register port.
// ----------------------------------------------------------------------------
// Takes one sample index request per clock while the pipeline is not stalled
// and returns its sample through three rows of long division cells that
// produce one quotient bit each (IndexWidth cells for the phase remainder, two
// for the quadrant, thirty for the Q30 fraction), two multiply stages for the
// angle and its square, and six Taylor term cells of three stages each. The
// result sits in an output register; while it waits, the pipeline still
// advances as long as its last stage is empty. Write period, phase, delay and
// end sample over APB only while no request is in flight; a period of zero
// acts as one.
module windowed_sine_generator #(
  parameter int unsigned IndexWidth = wsg_pkg::IndexWidthDef,
  parameter int unsigned OutWidth   = wsg_pkg::OutWidthDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  wsg_in_if.sink                             in_i,
  wsg_out_if.source                          out_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [wsg_pkg::ApbAddrWidth-1:0]   paddr,
  input  logic [wsg_pkg::ApbDataWidth-1:0]   pwdata,
  output logic [wsg_pkg::ApbDataWidth-1:0]   prdata,
  output logic                               pready
);
  import wsg_pkg::*;

  localparam int unsigned W      = IndexWidth;
  localparam int unsigned MagW   = OutWidth - 1;
  localparam int unsigned Shift  = FracBits - MagW;
  localparam int unsigned TW     = FracBits + 1;
  localparam int unsigned RndW   = SumWidth;

  // configuration registers
  logic [W-1:0] period_q, phase_q, delay_q, end_q, p_eff_q;
  logic         cfg_we;
  wsg_reg_e     reg_sel;

  assign cfg_we  = psel && penable && pwrite;
  assign reg_sel = wsg_reg_e'(paddr[ApbAddrWidth-1:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= W'(1);
      p_eff_q  <= W'(1);
      phase_q  <= '0;
      delay_q  <= '0;
      end_q    <= '1;
    end else if (cfg_we) begin
      case (reg_sel)
        RegPeriod: begin
          period_q <= pwdata[W-1:0];
          p_eff_q  <= (pwdata[W-1:0] == '0) ? W'(1) : pwdata[W-1:0];
        end
        RegPhase: phase_q <= pwdata[W-1:0];
        RegDelay: delay_q <= pwdata[W-1:0];
        RegEnd:   end_q   <= pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_sel)
      RegPeriod: prdata[W-1:0] = period_q;
      RegPhase:  prdata[W-1:0] = phase_q;
      RegDelay:  prdata[W-1:0] = delay_q;
      RegEnd:    prdata[W-1:0] = end_q;
      default:   prdata = '0;
    endcase
  end

  // pipeline advance
  logic     en, out_ld;
  logic     out_valid_q;
  wsg_tag_t m_tag_q;

  assign out_ld   = !out_valid_q || out_o.ready;
  assign en       = out_ld || !m_tag_q.valid;
  assign in_i.ready = en;

  // input stage: window test and phase distance
  wsg_tag_t     s0_tag_d, s0_tag_q;
  logic [W-1:0] s0_abs_d, s0_abs_q;
  logic         ge_phase;

  always_comb begin
    ge_phase        = in_i.sample_index >= phase_q;
    s0_abs_d        = ge_phase ? (in_i.sample_index - phase_q)
                               : (phase_q - in_i.sample_index);
    s0_tag_d.valid  = in_i.valid;
    s0_tag_d.in_win = (in_i.sample_index > delay_q) && (in_i.sample_index <= end_q);
    s0_tag_d.neg    = !ge_phase;
    s0_tag_d.hi     = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_tag_q <= '0;
    end else if (en) begin
      s0_tag_q <= s0_tag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_abs_q <= s0_abs_d;
    end
  end

  // distance mod period
  wsg_tag_t     a_tag [W+1];
  logic [W-1:0] a_rem [W+1];
  logic [W-1:0] a_acc [W+1];

  assign a_tag[0] = s0_tag_q;
  assign a_rem[0] = '0;
  assign a_acc[0] = s0_abs_q;

  for (genvar i = 0; i < W; i++) begin : gen_mod_cells
    wsg_div_cell #(
      .RemWidth(W),
      .AccWidth(W)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .divisor_i(p_eff_q),
      .tag_i    (a_tag[i]),
      .rem_i    (a_rem[i]),
      .acc_i    (a_acc[i]),
      .tag_o    (a_tag[i+1]),
      .rem_o    (a_rem[i+1]),
      .acc_o    (a_acc[i+1])
    );
  end

  // fold negative distance back into [0, period)
  wsg_tag_t     f_tag_q;
  logic [W-1:0] f_rem_d, f_rem_q;

  assign f_rem_d = (a_tag[W].neg && (a_rem[W] != '0)) ? (p_eff_q - a_rem[W]) : a_rem[W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_tag_q <= '0;
    end else if (en) begin
      f_tag_q <= a_tag[W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_rem_q <= f_rem_d;
    end
  end

  // quadrant
  wsg_tag_t     b_tag [3];
  logic [W-1:0] b_rem [3];
  logic [1:0]   b_acc [3];

  assign b_tag[0] = f_tag_q;
  assign b_rem[0] = f_rem_q;
  assign b_acc[0] = '0;

  for (genvar i = 0; i < 2; i++) begin : gen_quad_cells
    wsg_div_cell #(
      .RemWidth(W),
      .AccWidth(2)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .divisor_i(p_eff_q),
      .tag_i    (b_tag[i]),
      .rem_i    (b_rem[i]),
      .acc_i    (b_acc[i]),
      .tag_o    (b_tag[i+1]),
      .rem_o    (b_rem[i+1]),
      .acc_o    (b_acc[i+1])
    );
  end

  // mirror odd quadrants; full quarter sets the top fraction bit
  wsg_tag_t     u_tag_d, u_tag_q;
  logic [W-1:0] u_rem_d, u_rem_q;
  logic         m_zero;

  always_comb begin
    m_zero          = b_rem[2] == '0;
    u_tag_d         = b_tag[2];
    u_tag_d.neg     = b_acc[2][1];
    u_tag_d.hi      = b_acc[2][0] && m_zero;
    if (b_acc[2][0]) begin
      u_rem_d = m_zero ? '0 : (p_eff_q - b_rem[2]);
    end else begin
      u_rem_d = b_rem[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_tag_q <= '0;
    end else if (en) begin
      u_tag_q <= u_tag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      u_rem_q <= u_rem_d;
    end
  end

  // Q30 fraction of the quarter period
  wsg_tag_t            c_tag [FracBits+1];
  logic [W-1:0]        c_rem [FracBits+1];
  logic [FracBits-1:0] c_acc [FracBits+1];

  assign c_tag[0] = u_tag_q;
  assign c_rem[0] = u_rem_q;
  assign c_acc[0] = '0;

  for (genvar i = 0; i < FracBits; i++) begin : gen_frac_cells
    wsg_div_cell #(
      .RemWidth(W),
      .AccWidth(FracBits)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .divisor_i(p_eff_q),
      .tag_i    (c_tag[i]),
      .rem_i    (c_rem[i]),
      .acc_i    (c_acc[i]),
      .tag_o    (c_tag[i+1]),
      .rem_o    (c_rem[i+1]),
      .acc_o    (c_acc[i+1])
    );
  end

  // angle and its square
  wsg_tag_t              th_tag_q, t2_tag_q;
  logic [TW-1:0]         frac_t;
  logic [2*TW-1:0]       th_prod;
  logic [ThetaWidth-1:0] th_q, t2_th_q;
  logic [2*ThetaWidth-1:0] sq_prod;
  logic [TermWidth-1:0]  t2_sq_q;

  assign frac_t  = {c_tag[FracBits].hi, c_acc[FracBits]};
  assign th_prod = (2*TW)'(frac_t) * (2*TW)'(HalfPiQ30);
  assign sq_prod = (2*ThetaWidth)'(th_q) * (2*ThetaWidth)'(th_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      th_tag_q <= '0;
      t2_tag_q <= '0;
    end else if (en) begin
      th_tag_q <= c_tag[FracBits];
      t2_tag_q <= th_tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      th_q    <= th_prod[FracBits+ThetaWidth-1:FracBits];
      t2_th_q <= th_q;
      t2_sq_q <= sq_prod[FracBits+TermWidth-1:FracBits];
    end
  end

  // Taylor series
  wsg_tag_t                   k_tag  [NumTerms+1];
  logic [TermWidth-1:0]       k_th2  [NumTerms+1];
  logic [TermWidth-1:0]       k_term [NumTerms+1];
  logic signed [SumWidth-1:0] k_sum  [NumTerms+1];

  assign k_tag[0]  = t2_tag_q;
  assign k_th2[0]  = t2_sq_q;
  assign k_term[0] = TermWidth'(t2_th_q);
  assign k_sum[0]  = $signed(SumWidth'(t2_th_q));

  for (genvar k = 0; k < NumTerms; k++) begin : gen_term_cells
    wsg_term_cell #(
      .TermIdx(k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .tag_i   (k_tag[k]),
      .theta2_i(k_th2[k]),
      .term_i  (k_term[k]),
      .sum_i   (k_sum[k]),
      .tag_o   (k_tag[k+1]),
      .theta2_o(k_th2[k+1]),
      .term_o  (k_term[k+1]),
      .sum_o   (k_sum[k+1])
    );
  end

  // clamp, round and saturate the magnitude
  logic [RndW-1:0] clamped, rounded, mag_full;
  logic [MagW-1:0] m_mag_d, m_mag_q;

  always_comb begin
    clamped  = k_sum[NumTerms][SumWidth-1] ? '0 : RndW'(k_sum[NumTerms]);
    rounded  = clamped + (RndW'(1) << (Shift - 1));
    mag_full = rounded >> Shift;
    m_mag_d  = (|mag_full[RndW-1:MagW]) ? '1 : mag_full[MagW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tag_q <= '0;
    end else if (en) begin
      m_tag_q <= k_tag[NumTerms];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_mag_q <= m_mag_d;
    end
  end

  // output register
  logic [OutWidth-1:0] mag_ext, value_d, value_q;
  logic                window_q;

  always_comb begin
    mag_ext = {1'b0, m_mag_q};
    if (!m_tag_q.in_win) begin
      value_d = '0;
    end else if (m_tag_q.neg) begin
      value_d = '0 - mag_ext;
    end else begin
      value_d = mag_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ld) begin
      out_valid_q <= m_tag_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      value_q  <= value_d;
      window_q <= m_tag_q.in_win;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.sample_value = $signed(value_q);
  assign out_o.in_window    = window_q;

endmodule

/* design/wsg_checker.sv */
// ----------------------------------------------------------------------------
// Windowed sine generator checker
// Port-level properties of the generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "windowed_sine_generator_defines.svh"

module wsg_checker #(
  parameter int unsigned IndexWidth = wsg_pkg::IndexWidthDef,
  parameter int unsigned OutWidth   = wsg_pkg::OutWidthDef
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_ready_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic [OutWidth-1:0]                sample_value_i,
  input logic                               in_window_i,
  input logic                               psel_i,
  input logic                               penable_i,
  input logic                               pwrite_i,
  input logic [wsg_pkg::ApbAddrWidth-1:0]   paddr_i,
  input logic [wsg_pkg::ApbDataWidth-1:0]   pwdata_i,
  input logic [wsg_pkg::ApbDataWidth-1:0]   prdata_i
);
  import wsg_pkg::*;

  localparam logic [ApbDataWidth-1:0] RegMask =
    ApbDataWidth'((64'd1 << IndexWidth) - 64'd1);
  localparam logic [OutWidth-1:0] MinValue = {1'b1, {(OutWidth-1){1'b0}}};

  `WSG_ASSERT(zero_outside_window_a, (out_valid_i && !in_window_i) |-> (sample_value_i == '0))
  `WSG_ASSERT_NEVER(no_min_value_a, out_valid_i && (sample_value_i == MinValue))
  `WSG_ASSERT(held_result_a, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(sample_value_i) && $stable(in_window_i)))
  `WSG_ASSERT(ready_when_empty_a, !out_valid_i |-> in_ready_i)
  `WSG_ASSERT(readback_a, (psel_i && penable_i && pwrite_i) ##1 (psel_i && !pwrite_i && (paddr_i == $past(paddr_i))) |-> (prdata_i == ($past(pwdata_i) & RegMask)))

endmodule

bind windowed_sine_generator wsg_checker #(
  .IndexWidth(IndexWidth),
  .OutWidth  (OutWidth)
) u_wsg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .sample_value_i(out_o.sample_value),
  .in_window_i   (out_o.in_window),
  .psel_i        (psel),
  .penable_i     (penable),
  .pwrite_i      (pwrite),
  .paddr_i       (paddr),
  .pwdata_i      (pwdata),
  .prdata_i      (prdata)
);

/* verif/windowed_sine_checker.sv */
// ----------------------------------------------------------------------------
// Windowed sine generator checker
// Watches the request, result and register channels, predicts each sample
// from the register values snooped off the bus and compares it in order.
// ----------------------------------------------------------------------------
module windowed_sine_checker #(
  parameter int unsigned IndexWidth = wsg_pkg::IndexWidthDef,
  parameter int unsigned OutWidth   = wsg_pkg::OutWidthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  wsg_in_if                                in_i,
  wsg_out_if                               out_i,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [wsg_pkg::ApbAddrWidth-1:0] paddr,
  input  logic [wsg_pkg::ApbDataWidth-1:0] pwdata,
  input  logic                             pready,
  output int                               errors_o,
  output int                               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import wsg_pkg::*;

  typedef struct packed {
    logic signed [OutWidth-1:0] value;
    logic                       in_window;
  } sample_t;

  logic [IndexWidth-1:0] period_r;
  logic [IndexWidth-1:0] phase_r;
  logic [IndexWidth-1:0] delay_r;
  logic [IndexWidth-1:0] end_r;

  sample_t samples_due_q[$];
  sample_t want;
  int      mismatch_count;

  function automatic sample_t predict_sample(input logic [IndexWidth-1:0] idx);
    sample_t     res;
    bit [63:0]   per;
    bit [63:0]   r;
    bit [63:0]   four_r;
    bit [63:0]   q;
    bit [63:0]   m;
    bit [63:0]   u;
    bit [63:0]   t;
    bit [63:0]   half_pi;
    bit [63:0]   theta;
    bit [63:0]   theta2;
    bit [63:0]   term;
    bit [63:0]   mag;
    bit [63:0]   maxv;
    longint      diff;
    longint      rs;
    longint      acc;
    int unsigned k;
    res.value     = '0;
    res.in_window = 1'b0;
    if (idx > delay_r && idx <= end_r) begin
      per  = (period_r == '0) ? 64'd1 : 64'(period_r);
      diff = longint'(64'(idx)) - longint'(64'(phase_r));
      rs   = diff % longint'(per);
      if (rs < 0) begin
        rs = rs + longint'(per);
      end
      r      = 64'(rs);
      four_r = r << 2;
      q      = four_r / per;
      m      = four_r - q * per;
      u      = q[0] ? (per - m) : m;
      t      = (u << FracBits) / per;
      if (t > (64'd1 << FracBits)) begin
        t = 64'd1 << FracBits;
      end
      half_pi = 64'(HalfPiQ30);
      theta   = (t * half_pi) >> FracBits;
      theta2  = (theta * theta) >> FracBits;
      term    = theta;
      acc     = longint'(theta);
      for (k = 1; k <= NumTerms; k++) begin
        term = ((term * theta2) >> FracBits) / 64'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      mag  = ((64'(acc) << (OutWidth - 1)) + (64'd1 << (FracBits - 1))) >> FracBits;
      maxv = (64'd1 << (OutWidth - 1)) - 64'd1;
      if (mag > maxv) begin
        mag = maxv;
      end
      res.value     = q[1] ? -mag[OutWidth-1:0] : mag[OutWidth-1:0];
      res.in_window = 1'b1;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samples_due_q.delete();
      period_r       <= IndexWidth'(1);
      phase_r        <= '0;
      delay_r        <= '0;
      end_r          <= '1;
      mismatch_count = 0;
      errors_o       <= 0;
      pending_o      <= 0;
    end else begin
      if (out_i.valid && out_i.ready) begin
        if (samples_due_q.size() == 0) begin
          $display("%0t: unrequested sample: expected none, actual value %0d in_window %0b",
                   $time, out_i.sample_value, out_i.in_window);
          mismatch_count++;
        end else begin
          want = samples_due_q.pop_front();
          if (out_i.sample_value !== want.value) begin
            $display("%0t: sample_value mismatch: expected %0d actual %0d",
                     $time, want.value, out_i.sample_value);
            mismatch_count++;
          end
          if (out_i.in_window !== want.in_window) begin
            $display("%0t: in_window mismatch: expected %0b actual %0b",
                     $time, want.in_window, out_i.in_window);
            mismatch_count++;
          end
        end
      end
      if (in_i.valid && in_i.ready) begin
        samples_due_q.push_back(predict_sample(in_i.sample_index));
      end
      if (psel && penable && pwrite && pready) begin
        case (wsg_reg_e'(paddr[ApbAddrWidth-1:2]))
          RegPeriod: period_r <= pwdata[IndexWidth-1:0];
          RegPhase:  phase_r  <= pwdata[IndexWidth-1:0];
          RegDelay:  delay_r  <= pwdata[IndexWidth-1:0];
          RegEnd:    end_r    <= pwdata[IndexWidth-1:0];
          default: begin
          end
        endcase
      end
      errors_o  <= mismatch_count;
      pending_o <= samples_due_q.size();
    end
  end

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// Windowed sine generator testbench
// Drives sample index requests and register writes through a series of
// directed and random window/period settings, with random gaps and stalls on
// both streams, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wsg_pkg::*;

  localparam int unsigned IndexWidth    = IndexWidthDef;
  localparam int unsigned OutWidth      = OutWidthDef;
  localparam int unsigned IndexMax      = (1 << IndexWidth) - 1;
  localparam int unsigned CycleLimit    = 1000000;
  localparam int unsigned DrainCycles   = 120;
  localparam int unsigned RandomPhases  = 8;
  localparam int unsigned ItemsPerPhase = 150;
  localparam int unsigned HoldOffCycles = 400;

  logic                    clk_i  = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [ApbAddrWidth-1:0] paddr;
  logic [ApbDataWidth-1:0] pwdata;
  logic [ApbDataWidth-1:0] prdata;
  logic                    pready;
  int                      errors;
  int                      pending;
  int unsigned             cycle_count = 0;
  bit                      hold_off_req  = 1'b0;
  bit                      hold_off_done = 1'b0;

  wsg_in_if  #(.IndexWidth(IndexWidth)) in_if ();
  wsg_out_if #(.OutWidth(OutWidth))     out_if ();

  windowed_sine_generator #(
    .IndexWidth(IndexWidth),
    .OutWidth  (OutWidth)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  windowed_sine_checker #(
    .IndexWidth(IndexWidth),
    .OutWidth  (OutWidth)
  ) u_checker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_if),
    .out_i    (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .pready   (pready),
    .errors_o (errors),
    .pending_o(pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic apb_write(input wsg_reg_e reg_sel, input int unsigned value);
    logic [ApbDataWidth-1:0] word;
    word                   = $urandom;
    word[IndexWidth-1:0]   = value[IndexWidth-1:0];
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrWidth'({reg_sel, 2'b00});
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(input int unsigned per, input int unsigned ph,
                           input int unsigned dly, input int unsigned end_value);
    in_if.valid <= 1'b0;
    wait_drained();
    apb_write(RegPeriod, per);
    apb_write(RegPhase, ph);
    apb_write(RegDelay, dly);
    apb_write(RegEnd, end_value);
  endtask

  task automatic send_index(input int unsigned idx, input bit with_gaps);
    int unsigned roll;
    int unsigned gap;
    gap = 0;
    if (with_gaps) begin
      roll = $urandom_range(0, 99);
      if (roll >= 95) begin
        gap = $urandom_range(10, 40);
      end else if (roll >= 70) begin
        gap = $urandom_range(1, 4);
      end
    end
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.sample_index <= idx[IndexWidth-1:0];
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  initial begin
    int unsigned mode;
    int unsigned run;
    out_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        out_if.ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_off_done = 1'b1;
      end else begin
        mode = $urandom_range(0, 99);
        if (mode < 60) begin
          out_if.ready <= 1'b1;
          run = $urandom_range(1, 30);
        end else if (mode < 92) begin
          out_if.ready <= 1'b0;
          run = $urandom_range(1, 3);
        end else begin
          out_if.ready <= 1'b0;
          run = $urandom_range(10, 40);
        end
        repeat (run) @(posedge clk_i);
      end
    end
  end

  initial begin
    int unsigned quad_points[]  = '{1, 4, 6, 8, 12, 14, 16};
    int unsigned window_edges[] = '{100, 101, 150, 200, 201};
    int unsigned per;
    int unsigned ph;
    int unsigned dly;
    int unsigned end_value;
    int unsigned lo;
    int unsigned hi;
    int unsigned pick;
    int unsigned idx;
    bit          with_gaps;

    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    in_if.valid        <= 1'b0;
    in_if.sample_index <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_index(0, 1'b0);
    send_index(1, 1'b0);
    send_index(IndexMax, 1'b0);

    configure(16, 0, 0, IndexMax);
    foreach (quad_points[i]) send_index(quad_points[i], 1'b0);

    configure(1000, IndexMax, 100, 200);
    foreach (window_edges[i]) send_index(window_edges[i], 1'b1);

    configure(0, 5, 0, IndexMax);
    send_index(7, 1'b0);
    send_index(123456, 1'b0);

    configure(IndexMax, 0, IndexMax, 0);
    send_index(IndexMax, 1'b0);
    send_index(0, 1'b0);

    configure(IndexMax, 123, 0, IndexMax);
    send_index(IndexMax, 1'b0);
    send_index(IndexMax / 4 + 1, 1'b0);
    send_index(3 * (IndexMax / 4) + 3, 1'b0);

    for (int unsigned p = 0; p < RandomPhases; p++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        per = $urandom_range(1, 8);
      end else if (pick < 5) begin
        per = $urandom_range(2, 512);
      end else if (pick < 8) begin
        per = $urandom_range(513, 1 << 20);
      end else if (pick == 8) begin
        per = $urandom & IndexMax;
      end else begin
        per = IndexMax;
      end
      ph   = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 64) : ($urandom & IndexMax);
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        dly       = $urandom_range(0, 64);
        end_value = IndexMax;
      end else if (pick < 9) begin
        lo        = $urandom & IndexMax;
        hi        = $urandom & IndexMax;
        dly       = (lo < hi) ? lo : hi;
        end_value = (lo < hi) ? hi : lo;
      end else begin
        dly       = $urandom & IndexMax;
        end_value = $urandom & IndexMax;
      end
      configure(per, ph, dly, end_value);
      if (p == 2) begin
        hold_off_req = 1'b1;
      end
      with_gaps = (p % 3 != 0);
      for (int unsigned i = 0; i < ItemsPerPhase; i++) begin
        pick = $urandom_range(0, 9);
        if (pick < 7 && end_value > dly) begin
          idx = $urandom_range(dly + 1, end_value);
        end else if (pick < 8) begin
          case ($urandom_range(0, 3))
            0:       idx = dly;
            1:       idx = dly + 1;
            2:       idx = end_value;
            default: idx = end_value + 1;
          endcase
        end else begin
          idx = $urandom;
        end
        send_index(idx & IndexMax, with_gaps);
      end
    end

    in_if.valid <= 1'b0;
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
